/* hw/rtl/pkc_pkg.sv */
// Shared types, register codes, character constants and helpers of the progressive keyed cipher.
package pkc_pkg;

    localparam int KEY_SLOTS = 24;

    typedef logic [2:0] cfg_index_t;
    typedef logic [4:0] letter_t;
    typedef logic [KEY_SLOTS-1:0][4:0] key_array_t;

    localparam cfg_index_t CFG_DIRECTION    = 3'd0;
    localparam cfg_index_t CFG_SHIFT_OFFSET = 3'd1;
    localparam cfg_index_t CFG_KEY_LENGTH   = 3'd2;
    localparam cfg_index_t CFG_KEY_LOW      = 3'd3;
    localparam cfg_index_t CFG_KEY_HIGH     = 3'd4;

    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_Z     = 8'h7A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [5:0] ALPHA      = 6'd26;

    // Item as it leaves the input stage.
    typedef struct packed {
        logic [7:0] ch;
        logic       is_lower;
        letter_t    pos_key;
        logic       bad;
        logic       last;
    } pkc_item_t;

    // Sequence state as seen from outside the input stage.
    typedef struct packed {
        letter_t    position;
        logic [4:0] key_index;
    } pkc_status_t;

    // Reduce a value below 52 into 0..25.
    function automatic letter_t mod26_fold(input logic [5:0] v);
        logic [5:0] r;
        r = (v >= ALPHA) ? (v - ALPHA) : v;
        return r[4:0];
    endfunction

endpackage

/* hw/rtl/pkc_front.sv */
// Input stage: sequence counters, key letter selection and the input register.
module pkc_front #(
    parameter int KEY_MAX = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                drain,
    input  logic [7:0]          char_in,
    input  logic                last_in,
    input  logic [4:0]          key_length,
    input  pkc_pkg::key_array_t key_letters,
    output logic                item_valid,
    output pkc_pkg::pkc_item_t  item,
    output pkc_pkg::pkc_status_t status
);

    pkc_pkg::letter_t   position_reg, position_next;
    logic [4:0]         key_index_reg, key_index_next;
    logic               error_seen_reg, error_seen_next;
    logic               valid_reg, valid_next;
    pkc_pkg::pkc_item_t item_reg, item_next;

    logic [4:0]         len;
    logic [4:0]         idx;
    pkc_pkg::letter_t   key_letter;
    logic               is_lower;
    logic               bad;

    always_comb
    begin
        if (key_length == 5'd0)
            len = 5'd1;
        else if (key_length > 5'(KEY_MAX))
            len = 5'(KEY_MAX);
        else
            len = key_length;

        idx        = (key_index_reg < len) ? key_index_reg : 5'd0;
        key_letter = pkc_pkg::mod26_fold({1'b0, key_letters[idx]});
        is_lower   = char_in inside {[pkc_pkg::CHAR_A:pkc_pkg::CHAR_Z]};
        bad        = error_seen_reg | (!is_lower && (char_in != pkc_pkg::CHAR_SPACE));

        item_next.ch       = char_in;
        item_next.is_lower = is_lower;
        item_next.pos_key  = pkc_pkg::mod26_fold(6'(position_reg) + 6'(key_letter));
        item_next.bad      = bad;
        item_next.last     = last_in;

        position_next   = position_reg;
        key_index_next  = key_index_reg;
        error_seen_next = error_seen_reg;
        if (accept)
        begin
            if (last_in)
            begin
                position_next   = '0;
                key_index_next  = '0;
                error_seen_next = 1'b0;
            end
            else
            begin
                position_next   = pkc_pkg::mod26_fold(6'(position_reg) + 6'd1);
                key_index_next  = ((6'(idx) + 6'd1) >= 6'(len)) ? 5'd0 : (idx + 5'd1);
                error_seen_next = bad;
            end
        end

        if (accept)
            valid_next = 1'b1;
        else if (drain)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            key_index_reg  <= '0;
            error_seen_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            position_reg   <= position_next;
            key_index_reg  <= key_index_next;
            error_seen_reg <= error_seen_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign item_valid       = valid_reg;
    assign item             = item_reg;
    assign status.position  = position_reg;
    assign status.key_index = key_index_reg;

endmodule

/* hw/rtl/pkc_back.sv */
// Result stage: applies the total shift to a letter and holds the result register.
module pkc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               item_valid,
    input  pkc_pkg::pkc_item_t item,
    input  logic               direction,
    input  logic [4:0]         shift_offset,
    output logic               out_valid,
    output logic [7:0]         char_out,
    output logic               bad_message,
    output logic               last_out
);

    logic             valid_reg, valid_next;
    logic [7:0]       char_reg, char_next;
    logic             bad_reg;
    logic             last_reg;

    pkc_pkg::letter_t offset;
    pkc_pkg::letter_t shift;
    pkc_pkg::letter_t v;
    pkc_pkg::letter_t shifted;

    always_comb
    begin
        offset = pkc_pkg::mod26_fold({1'b0, shift_offset});
        shift  = pkc_pkg::mod26_fold(6'(offset) + 6'(item.pos_key));
        v      = 5'(item.ch - pkc_pkg::CHAR_A);
        if (!direction)
            shifted = pkc_pkg::mod26_fold(6'(v) + 6'(shift));
        else
            shifted = pkc_pkg::mod26_fold(6'(v) + pkc_pkg::ALPHA - 6'(shift));
        char_next  = item.is_lower ? (pkc_pkg::CHAR_A + 8'(shifted)) : item.ch;
        valid_next = advance ? item_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            char_reg <= char_next;
            bad_reg  <= item.bad;
            last_reg <= item.last;
        end
    end

    assign out_valid   = valid_reg;
    assign char_out    = char_reg;
    assign bad_message = bad_reg;
    assign last_out    = last_reg;

endmodule

/* hw/rtl/progressive_keyed_letter_cipher_top.sv */
// Top level of the progressive keyed letter cipher: configuration registers and stage control.
// Each character passes through the input register, then the result register, before it
// is on the output port.
// Throughput: one character per clock while the output is not stalled.
// Reset: counters, error flag and valid bits clear at once; registers return to encode,
// zero offset, key length one and all key letters zero.
module progressive_keyed_letter_cipher_top #(
    parameter int KEY_MAX = 24
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [59:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        last_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_out,
    output logic        bad_message,
    output logic        last_out
);

    // Configuration registers, written one at a time; write them only while the block is idle (not enforced).
    logic        direction_reg;
    logic [4:0]  shift_offset_reg;
    logic [4:0]  key_length_reg;
    logic [59:0] key_low_reg;
    logic [59:0] key_high_reg;

    // Stage control.
    //   advance: the result register is free or is being emptied this cycle,
    //            so the input register can move forward.
    //   accept:  an input transfer; the input register is free or moving.
    logic                 advance;
    logic                 accept;
    logic                 item_valid;
    pkc_pkg::pkc_item_t   item;
    pkc_pkg::pkc_status_t status;
    pkc_pkg::key_array_t  key_letters;

    assign cfg_ready   = 1'b1;
    assign advance     = !out_valid || !out_stall;
    assign in_stall    = item_valid && !advance;
    assign accept      = in_valid && !in_stall;
    assign key_letters = {key_high_reg, key_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= 1'b0;
            shift_offset_reg <= '0;
            key_length_reg   <= 5'd1;
            key_low_reg      <= '0;
            key_high_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pkc_pkg::CFG_DIRECTION:    direction_reg    <= cfg_data[0];
                pkc_pkg::CFG_SHIFT_OFFSET: shift_offset_reg <= cfg_data[4:0];
                pkc_pkg::CFG_KEY_LENGTH:   key_length_reg   <= cfg_data[4:0];
                pkc_pkg::CFG_KEY_LOW:      key_low_reg      <= cfg_data;
                pkc_pkg::CFG_KEY_HIGH:     key_high_reg     <= cfg_data;
                default:                   ; // drop writes to unused indexes
            endcase
        end
    end

    // First stage: the position and key counters advance on each transfer, restart after the last
    // character of a message, and the position-plus-key part of the shift is folded modulo 26.
    pkc_front #(
        .KEY_MAX (KEY_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .drain       (advance),
        .char_in     (char_in),
        .last_in     (last_in),
        .key_length  (key_length_reg),
        .key_letters (key_letters),
        .item_valid  (item_valid),
        .item        (item),
        .status      (status)
    );

    // Second stage: add the base offset and shift the letter in either direction.
    pkc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item),
        .direction    (direction_reg),
        .shift_offset (shift_offset_reg),
        .out_valid    (out_valid),
        .char_out     (char_out),
        .bad_message  (bad_message),
        .last_out     (last_out)
    );

    // A full input register behind a stalled result must push back on the input.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && out_valid && out_stall) |-> in_stall)
        else $error("input taken while both stages are held");

    // Counters stay inside their ranges.
    a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (status.position < 5'd26) && (status.key_index < 5'(KEY_MAX)))
        else $error("sequence counter out of range");

    // The end of a message restarts the sequence.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_in) |=> (status.position == 5'd0 && status.key_index == 5'd0))
        else $error("sequence not restarted after last character");

endmodule

/* bench/progressive_keyed_letter_cipher_top_test.sv */
// Self-checking testbench for the progressive keyed letter cipher top level.
`timescale 1ns / 100ps

module progressive_keyed_letter_cipher_top_test;

    localparam int KEY_MAX      = 24;
    localparam int DRAIN_CYCLES = 6;      // margin for the pipeline to empty
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_CHARS  = 50;

    // One character as it enters, and one as it should leave.
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } plain_char_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       bad;
        logic       last;
    } cipher_char_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    pkc_pkg::cfg_index_t cfg_index   = pkc_pkg::CFG_DIRECTION;
    logic [59:0]         cfg_data    = '0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [7:0]          char_in     = 8'h00;
    logic                last_in     = 1'b0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [7:0]          char_out;
    logic                bad_message;
    logic                last_out;

    progressive_keyed_letter_cipher_top #(
        .KEY_MAX(KEY_MAX)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_out   (char_out),
        .bad_message(bad_message),
        .last_out   (last_out)
    );

    // Shadow of the configuration registers, updated on each register transfer.
    logic        dir_sh      = 1'b0;
    logic [4:0]  offset_sh   = 5'd0;
    logic [4:0]  keylen_sh   = 5'd1;
    logic [59:0] key_low_sh  = '0;
    logic [59:0] key_high_sh = '0;

    // Shadow of the message state.
    int unsigned msg_pos     = 0;
    int unsigned msg_key_idx = 0;
    logic        msg_err     = 1'b0;

    plain_char_t  plaintext_q[$];      // characters waiting to be driven
    cipher_char_t pending_cipher[$];   // expected results, oldest first

    int   n_loaded   = 0;
    int   n_taken    = 0;
    int   n_results  = 0;
    int   mismatches = 0;
    bit   no_idle    = 1'b0;
    logic in_took    = 1'b0;
    logic out_took   = 1'b0;
    int   gap_left   = 0;
    int   rx_hold    = 0;

    initial forever #1 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    // Wait before the next transfer on either side; some phases run without gaps.
    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 1))
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Compute the result of one character and advance the message state.
    function automatic cipher_char_t encipher_char(input logic [7:0] ch, input logic last);
        int unsigned  len;
        int unsigned  idx;
        int unsigned  shift;
        int unsigned  v;
        logic [4:0]   letter;
        cipher_char_t r;
        len = (keylen_sh == 0) ? 1 : ((keylen_sh > KEY_MAX) ? KEY_MAX : keylen_sh);
        // Key length lowered mid-message: fall back to letter 0.
        idx = (msg_key_idx < len) ? msg_key_idx : 0;
        letter = (idx < 12) ? key_low_sh[5*idx +: 5] : key_high_sh[5*(idx-12) +: 5];
        r.ch   = ch;
        r.bad  = msg_err;
        r.last = last;
        if (ch >= pkc_pkg::CHAR_A && ch <= pkc_pkg::CHAR_Z)
        begin
            shift = (offset_sh % 26 + msg_pos + letter % 26) % 26;
            v = ch - pkc_pkg::CHAR_A;
            v = dir_sh ? (v + 26 - shift) % 26 : (v + shift) % 26;
            r.ch = pkc_pkg::CHAR_A + 8'(v);
        end
        else if (ch != pkc_pkg::CHAR_SPACE)
            r.bad = 1'b1;
        if (last)
        begin
            msg_pos     = 0;
            msg_key_idx = 0;
            msg_err     = 1'b0;
        end
        else
        begin
            msg_pos     = (msg_pos + 1) % 26;
            msg_key_idx = (idx + 1 >= len) ? 0 : idx + 1;
            msg_err     = r.bad;
        end
        return r;
    endfunction

    // Input driver: hold a stalled character, else count down the gap, else load the next.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_took)
            ;
        else if (gap_left != 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (plaintext_q.size() != 0)
        begin
            plain_char_t p;
            p = plaintext_q.pop_front();
            char_in  <= p.ch;
            last_in  <= p.last;
            in_valid <= 1'b1;
            gap_left <= draw_wait();
        end
        else
            in_valid <= 1'b0;
    end

    // Output stall: draw a fresh hold-off after every result transfer.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_took)
                rx_hold = draw_wait();
            if (rx_hold != 0)
            begin
                out_stall <= 1'b1;
                rx_hold = rx_hold - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: check result transfers first, then predict accepted characters.
    always @(posedge clk or negedge rst_n)
    begin
        cipher_char_t want;
        cipher_char_t got;
        cipher_char_t predicted;
        if (!rst_n)
        begin
            in_took  <= 1'b0;
            out_took <= 1'b0;
        end
        else
        begin
            in_took  <= in_valid && !in_stall;
            out_took <= out_valid && !out_stall;
            if (out_valid && !out_stall)
            begin
                got = '{ch: char_out, bad: bad_message, last: last_out};
                if (pending_cipher.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: none expected, got char %h bad %b last %b",
                                 n_results, got.ch, got.bad, got.last);
                end
                else
                begin
                    want = pending_cipher.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected char %h bad %b last %b,",
                                      " got char %h bad %b last %b"},
                                     n_results, want.ch, want.bad, want.last,
                                     got.ch, got.bad, got.last);
                    end
                end
                n_results++;
            end
            if (in_valid && !in_stall)
            begin
                predicted = encipher_char(char_in, last_in);
                pending_cipher = {pending_cipher, predicted};
                n_taken++;
            end
        end
    end

    task automatic push_char(input logic [7:0] ch, input logic last);
        plain_char_t p;
        p.ch   = ch;
        p.last = last;
        plaintext_q = {plaintext_q, p};
        n_loaded++;
    endtask

    task automatic queue_text(input string s, input bit end_msg);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], end_msg && (i == s.len() - 1));
    endtask

    // Wait until every character is through, then let the pipeline empty.
    task automatic settle();
        while (n_taken != n_loaded || pending_cipher.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register and mirror it into the shadow copy.
    task automatic write_reg(input pkc_pkg::cfg_index_t idx, input logic [59:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            pkc_pkg::CFG_DIRECTION:    dir_sh      = val[0];
            pkc_pkg::CFG_SHIFT_OFFSET: offset_sh   = val[4:0];
            pkc_pkg::CFG_KEY_LENGTH:   keylen_sh   = val[4:0];
            pkc_pkg::CFG_KEY_LOW:      key_low_sh  = val;
            pkc_pkg::CFG_KEY_HIGH:     key_high_sh = val;
            default:                   ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Twelve key letters, mostly in range, some above 25.
    function automatic logic [59:0] pack_keys();
        logic [59:0] k;
        for (int n = 0; n < 12; n++)
            k[5*n +: 5] = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(26, 31))
                                                      : 5'($urandom_range(0, 25));
        return k;
    endfunction

    // Junk above the field, now and then, to exercise masking.
    function automatic logic [59:0] with_junk(input logic [59:0] v, input int bits);
        logic [59:0] junk;
        junk = 60'({$urandom(), $urandom()});
        if ($urandom_range(0, 3) != 0)
            return v;
        return v | (junk << bits);
    endfunction

    task automatic randomize_config(input int ph);
        logic [59:0] v;
        if (ph == 0 || $urandom_range(0, 1))
            write_reg(pkc_pkg::CFG_DIRECTION, with_junk(60'($urandom_range(0, 1)), 1));
        if (ph < 2 || $urandom_range(0, 1))
        begin
            if (ph == 0)
                v = '0;
            else if (ph == 1)
                v = 60'd25;
            else
                v = ($urandom_range(0, 4) == 0) ? 60'($urandom_range(26, 31))
                                                : 60'($urandom_range(0, 25));
            write_reg(pkc_pkg::CFG_SHIFT_OFFSET, with_junk(v, 5));
        end
        if (ph < 2 || $urandom_range(0, 1))
        begin
            if (ph == 0)
                v = 60'd24;
            else if (ph == 1)
                v = 60'd1;
            else if ($urandom_range(0, 5) == 0)
                v = $urandom_range(0, 1) ? 60'd0 : 60'($urandom_range(25, 31));
            else
                v = 60'($urandom_range(1, 24));
            write_reg(pkc_pkg::CFG_KEY_LENGTH, with_junk(v, 5));
        end
        if (ph == 0 || $urandom_range(0, 1))
            write_reg(pkc_pkg::CFG_KEY_LOW, pack_keys());
        if (ph == 0 || $urandom_range(0, 1))
            write_reg(pkc_pkg::CFG_KEY_HIGH, pack_keys());
    endtask

    // Clean text: letters with some spaces.
    function automatic logic [7:0] clean_char();
        if ($urandom_range(0, 5) == 0)
            return pkc_pkg::CHAR_SPACE;
        return pkc_pkg::CHAR_A + 8'($urandom_range(0, 25));
    endfunction

    initial
    begin
        int          budget;
        int          len;
        int          kind;
        logic [7:0]  ch;
        logic        carry;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: both letter ends, space, bytes just outside the letter range,
        // the byte extremes, a letter after an invalid byte, then a fresh message.
        queue_text("az ", 1'b0);
        push_char(8'h60, 1'b0);
        push_char(8'h7B, 1'b0);
        push_char(8'h00, 1'b0);
        push_char(pkc_pkg::CHAR_A + 8'd1, 1'b0);
        push_char(8'hFF, 1'b1);
        queue_text("q", 1'b1);
        settle();

        // Decode, offset and key length above range, key letters above 25.
        write_reg(pkc_pkg::CFG_DIRECTION, 60'd1);
        write_reg(pkc_pkg::CFG_SHIFT_OFFSET, 60'd31);
        write_reg(pkc_pkg::CFG_KEY_LENGTH, 60'd31);
        write_reg(pkc_pkg::CFG_KEY_LOW, '1);
        write_reg(pkc_pkg::CFG_KEY_HIGH, pack_keys());
        queue_text("zebra yak a", 1'b0);
        settle();

        // Shrink the key mid-message so the index lands past the new length.
        write_reg(pkc_pkg::CFG_KEY_LENGTH, 60'd2);
        queue_text("mnz", 1'b1);
        settle();

        // Zero key length, encode with the largest in-range offset.
        write_reg(pkc_pkg::CFG_KEY_LENGTH, 60'd0);
        write_reg(pkc_pkg::CFG_DIRECTION, 60'd0);
        write_reg(pkc_pkg::CFG_SHIFT_OFFSET, 60'd25);
        queue_text("za", 1'b1);
        settle();

        // Random phases: mostly clean messages, some with invalid bytes, some raw noise.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            randomize_config(ph);
            no_idle = (ph % 4 == 3);
            budget = PHASE_CHARS;
            while (budget > 0)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(27, 60)
                                                  : $urandom_range(1, 20);
                if (len > budget)
                    len = budget;
                budget -= len;
                kind = $urandom_range(0, 9);
                // Leave some phases mid-message so the state spans a register write.
                carry = (budget == 0) && ($urandom_range(0, 3) == 0);
                for (int i = 0; i < len; i++)
                begin
                    if (kind < 7)
                        ch = clean_char();
                    else if (kind < 9)
                        ch = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                         : clean_char();
                    else
                        ch = 8'($urandom_range(0, 255));
                    push_char(ch, (i == len - 1) && !carry);
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/pkc_pkg.sv
hw/rtl/pkc_front.sv
hw/rtl/pkc_back.sv
hw/rtl/progressive_keyed_letter_cipher_top.sv
bench/progressive_keyed_letter_cipher_top_test.sv
